// File: rtl/wsfp_pkg.sv
// Shared types and constants for the wheel speed frame parser.
`timescale 1ns / 1ps

package wsfp_pkg;

  localparam int unsigned DataLen    = 8;
  localparam int unsigned SpeedW     = 16;
  localparam int unsigned SumW       = 18;
  localparam int unsigned MaxSpeedW  = 16;
  localparam int unsigned ErrLimitW  = 8;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned OutDataW   = 120;

  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChSharp   = 8'h23;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChBang    = 8'h21;

  localparam logic [CfgIdxW-1:0] RegMaxSpeed   = 1'b0;
  localparam logic [CfgIdxW-1:0] RegErrorLimit = 1'b1;

  localparam logic [MaxSpeedW-1:0] MaxSpeedRst   = 16'd1000;
  localparam logic [ErrLimitW-1:0] ErrorLimitRst = 8'd5;

  typedef enum logic [4:0] {
    PhDollar  = 5'b00001,
    PhSharp   = 5'b00010,
    PhData    = 5'b00100,
    PhPercent = 5'b01000,
    PhBang    = 5'b10000
  } phase_e;

  typedef logic [DataLen-1:0][7:0] frame_t;

  typedef struct packed {
    logic   emit;
    phase_e phase;
  } parse_status_t;

  typedef struct packed {
    logic [SpeedW-1:0] speed_upper_left;
    logic [SpeedW-1:0] speed_lower_left;
    logic [SpeedW-1:0] speed_lower_right;
    logic [SpeedW-1:0] speed_upper_right;
    logic [SumW-1:0]   forward_sum;
    logic [SumW-1:0]   lateral_sum;
    logic [SumW-1:0]   turn_sum;
    logic              over_limit;
  } result_t;

endpackage

// File: rtl/wsfp_parser.sv
// Frame delimiter state machine, error counter and data byte store.
`timescale 1ns / 1ps

module wsfp_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           item_valid_i,
  input  logic                           item_take_i,
  input  logic [7:0]                     item_byte_i,
  input  logic [wsfp_pkg::ErrLimitW-1:0] error_limit_i,
  output wsfp_pkg::frame_t               frame_o,
  output wsfp_pkg::parse_status_t        status_o
);

  wsfp_pkg::phase_e phase_q, phase_d;
  logic [3:0] data_cnt_q, data_cnt_d;
  logic [7:0] err_cnt_q, err_cnt_d;
  wsfp_pkg::frame_t frame_q;
  logic [8:0] err_next;
  logic bad;
  logic resync;

  assign err_next = {1'b0, err_cnt_q} + 9'd1;
  assign resync   = err_next > {1'b0, error_limit_i};

  always_comb begin
    phase_d    = phase_q;
    data_cnt_d = data_cnt_q;
    bad        = 1'b0;
    unique case (phase_q)
      wsfp_pkg::PhSharp: begin
        if (item_byte_i == wsfp_pkg::ChSharp) begin
          phase_d    = wsfp_pkg::PhData;
          data_cnt_d = 4'd0;
        end else begin
          bad = 1'b1;
        end
      end
      wsfp_pkg::PhData: begin
        data_cnt_d = data_cnt_q + 4'd1;
        if (data_cnt_d >= 4'(wsfp_pkg::DataLen)) begin
          phase_d = wsfp_pkg::PhPercent;
        end
      end
      wsfp_pkg::PhPercent: begin
        if (item_byte_i == wsfp_pkg::ChPercent) begin
          phase_d = wsfp_pkg::PhBang;
        end else begin
          bad = 1'b1;
        end
      end
      wsfp_pkg::PhBang: begin
        if (item_byte_i == wsfp_pkg::ChBang) begin
          phase_d    = wsfp_pkg::PhDollar;
          data_cnt_d = 4'd0;
        end else begin
          bad = 1'b1;
        end
      end
      default: begin
        if (item_byte_i == wsfp_pkg::ChDollar) begin
          phase_d    = wsfp_pkg::PhSharp;
          data_cnt_d = 4'd0;
        end else begin
          bad = 1'b1;
        end
      end
    endcase
    err_cnt_d = err_cnt_q;
    if (bad) begin
      if (resync) begin
        phase_d    = wsfp_pkg::PhDollar;
        data_cnt_d = 4'd0;
        err_cnt_d  = 8'd0;
      end else begin
        err_cnt_d = err_next[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= wsfp_pkg::PhDollar;
      data_cnt_q <= 4'd0;
      err_cnt_q  <= 8'd0;
    end else if (item_take_i) begin
      phase_q    <= phase_d;
      data_cnt_q <= data_cnt_d;
      err_cnt_q  <= err_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_i && phase_q == wsfp_pkg::PhData) begin
      frame_q[data_cnt_q[2:0]] <= item_byte_i;
    end
  end

  assign frame_o         = frame_q;
  assign status_o.phase  = phase_q;
  assign status_o.emit   = item_valid_i && phase_q == wsfp_pkg::PhBang &&
                           item_byte_i == wsfp_pkg::ChBang;

endmodule

// File: rtl/wsfp_calc.sv
// Speed decode, limit compare and mecanum sums for one stored frame.
`timescale 1ns / 1ps

module wsfp_calc (
  input  wsfp_pkg::frame_t                frame_i,
  input  logic [wsfp_pkg::MaxSpeedW-1:0]  max_speed_i,
  output wsfp_pkg::result_t               result_o
);

  logic signed [wsfp_pkg::SpeedW-1:0] ul, ll, lr, ur;
  logic signed [wsfp_pkg::SumW-1:0]   ul_x, ll_x, lr_x, ur_x;
  logic signed [wsfp_pkg::MaxSpeedW:0] lim;

  assign ul = {frame_i[1], frame_i[0]};
  assign ll = {frame_i[3], frame_i[2]};
  assign lr = {frame_i[5], frame_i[4]};
  assign ur = {frame_i[7], frame_i[6]};

  assign ul_x = {{2{ul[15]}}, ul};
  assign ll_x = {{2{ll[15]}}, ll};
  assign lr_x = {{2{lr[15]}}, lr};
  assign ur_x = {{2{ur[15]}}, ur};

  assign lim = {1'b0, max_speed_i};

  assign result_o.speed_upper_left  = ul;
  assign result_o.speed_lower_left  = ll;
  assign result_o.speed_lower_right = lr;
  assign result_o.speed_upper_right = ur;
  assign result_o.forward_sum = ul_x + ll_x + lr_x + ur_x;
  assign result_o.lateral_sum = ll_x + lr_x - ul_x - ur_x;
  assign result_o.turn_sum    = ur_x + lr_x - ul_x - ll_x;
  assign result_o.over_limit  = ($signed(ul_x[16:0]) >= lim) ||
                                ($signed(ll_x[16:0]) >= lim) ||
                                ($signed(lr_x[16:0]) >= lim) ||
                                ($signed(ur_x[16:0]) >= lim);

endmodule

// File: rtl/wheel_speed_frame_parser.sv
// Top level of the wheel speed frame parser with input and result registers.
`timescale 1ns / 1ps

// The slave stream takes one received serial byte per item. Frames have the form
// '$' '#', eight data bytes, '%' '!'. On the closing '!' the master stream gives
// one item with the four little-endian wheel speeds, the forward, lateral and
// turn sums, and in tuser a flag that is set when any speed is at or above
// max_speed. Bytes that complete no frame give no item.
// The configuration port writes max_speed (index 0) or error_limit (index 1)
// on any edge with cfg_we_i high; write only while the block is idle.
// A taken byte is held in the input register; once the parser consumes it, a
// closing '!' has its result stored in the result register, which drives the
// item. Throughput is one byte per cycle while no closing '!' is held back,
// set by the combinational parser step between the two registers.
// Reset clears the parser to hunting for '$', the error count to zero, both
// registers to empty and the configuration to its defaults.
// While the receiver stalls, bytes that give no result keep flowing; a closing
// '!' waits in the input register until the result register is free.

module wheel_speed_frame_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // rx_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // speed_upper_left, speed_lower_left, speed_lower_right, speed_upper_right,
  // forward_sum, lateral_sum, turn_sum, zero fill
  output logic [wsfp_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                            m_axis_tuser,   // over_limit
  input  logic                            cfg_we_i,
  input  logic [wsfp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [wsfp_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic [wsfp_pkg::MaxSpeedW-1:0] max_speed_q;
  logic [wsfp_pkg::ErrLimitW-1:0] error_limit_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  wsfp_pkg::result_t result_q, result_d;
  wsfp_pkg::frame_t frame;
  wsfp_pkg::parse_status_t status;
  logic consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q   <= wsfp_pkg::MaxSpeedRst;
      error_limit_q <= wsfp_pkg::ErrorLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wsfp_pkg::RegMaxSpeed:   max_speed_q   <= cfg_data_i;
        wsfp_pkg::RegErrorLimit: error_limit_q <= cfg_data_i[wsfp_pkg::ErrLimitW-1:0];
        default: ;
      endcase
    end
  end

  assign consume       = in_valid_q && (!status.emit || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  wsfp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_q),
    .item_take_i  (consume),
    .item_byte_i  (in_byte_q),
    .error_limit_i(error_limit_q),
    .frame_o      (frame),
    .status_o     (status)
  );

  wsfp_calc u_calc (
    .frame_i    (frame),
    .max_speed_i(max_speed_q),
    .result_o   (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (consume && status.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && status.emit) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = result_q.over_limit;
  assign m_axis_tdata  = {2'b00,
                          result_q.turn_sum,
                          result_q.lateral_sum,
                          result_q.forward_sum,
                          result_q.speed_upper_right,
                          result_q.speed_lower_right,
                          result_q.speed_lower_left,
                          result_q.speed_upper_left};

  a_result_from_bang: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(consume && status.emit))
    else $error("result item without a closing byte");

  a_hunt_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && status.emit |=> status.phase == wsfp_pkg::PhDollar)
    else $error("parser did not return to hunting after a frame");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !consume |=> in_valid_q && $stable(in_byte_q))
    else $error("pending byte lost from the input register");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !(consume && status.emit))
    else $error("stalled result overwritten");

endmodule
